/* rtl/tte_pkg.sv */
// types, codes and arithmetic helpers shared by the tucker element evaluator
// no dependencies

package tte_pkg;

   localparam int WORD_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int ADDR_W      = 9;
   localparam int IDX_W       = 6;
   localparam int OP_W        = 3;
   localparam int RANK_W      = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic signed [WORD_W-1:0] Q_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] Q_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_CORE = 3'd0,
      OP_LOAD_F1   = 3'd1,
      OP_LOAD_F2   = 3'd2,
      OP_LOAD_F3   = 3'd3,
      OP_QUERY     = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RANK_FIRST  = 2'd0,
      CSR_RANK_SECOND = 2'd1,
      CSR_RANK_THIRD  = 2'd2
   } csr_reg_type;

   typedef enum logic [2:0] {
      CMD_CORE,
      CMD_FACT1,
      CMD_FACT2,
      CMD_FACT3,
      CMD_QUERY
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_DRAIN,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic [ADDR_W-1:0]        load_address;
      logic signed [WORD_W-1:0] load_value;
      logic [IDX_W-1:0]         index_first;
      logic [IDX_W-1:0]         index_second;
      logic [IDX_W-1:0]         index_third;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] element_value;
      logic                     saturated;
   } rsp_type;

   // classified item as it sits in the queue
   typedef struct packed {
      cmd_kind_type             kind;
      logic [ADDR_W-1:0]        addr;
      logic signed [WORD_W-1:0] value;
      logic [IDX_W-1:0]         idx1;
      logic [IDX_W-1:0]         idx2;
      logic [IDX_W-1:0]         idx3;
      logic [2:0]               row_ok;
   } cmd_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic                     clip;
   } qmul_type;

   // q16.16 multiply: floor shift by 16, then clip to 32 bits
   function automatic qmul_type qmul(input logic signed [WORD_W-1:0] x,
                                     input logic signed [WORD_W-1:0] y);
      logic signed [2*WORD_W-1:0]  prod;
      logic [2*WORD_W-FRAC_W-1:0]  q;
      logic                        fit;
      qmul_type                    res;
      prod = x * y;
      q = prod[2*WORD_W-1:FRAC_W];
      fit = (&q[2*WORD_W-FRAC_W-1:WORD_W-1]) || !(|q[2*WORD_W-FRAC_W-1:WORD_W-1]);
      res.clip = !fit;
      if (fit) begin
         res.value = q[WORD_W-1:0];
      end else begin
         res.value = q[2*WORD_W-FRAC_W-1] ? Q_MIN : Q_MAX;
      end
      return res;
   endfunction

endpackage

/* rtl/tte_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies

module tte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tte_front.sv */
// front end: decodes input items, drops ignored ones, checks ranges
// depends on tte_pkg

module tte_front import tte_pkg::*; #(
   parameter int RMAX = 8,
   parameter int NMAX = 64
) (
   input  logic    req_valid,
   input  req_type req_data,
   output logic    push_valid,
   output cmd_type push_data
);

   localparam int CORE_WORDS = RMAX * RMAX * RMAX;
   localparam int FACT_WORDS = NMAX * RMAX;

   logic core_in_range;
   logic fact_in_range;
   logic keep;

   assign core_in_range = int'(req_data.load_address) < CORE_WORDS;
   assign fact_in_range = int'(req_data.load_address) < FACT_WORDS;

   always_comb begin
      push_data.addr      = req_data.load_address;
      push_data.value     = req_data.load_value;
      push_data.idx1      = req_data.index_first;
      push_data.idx2      = req_data.index_second;
      push_data.idx3      = req_data.index_third;
      // rows past the factor height read as zero
      push_data.row_ok[0] = int'(req_data.index_first) < NMAX;
      push_data.row_ok[1] = int'(req_data.index_second) < NMAX;
      push_data.row_ok[2] = int'(req_data.index_third) < NMAX;
      push_data.kind      = CMD_QUERY;
      keep                = 1'b0;
      unique case (req_data.operation)
         OP_LOAD_CORE: begin
            push_data.kind = CMD_CORE;
            keep           = core_in_range;
         end
         OP_LOAD_F1: begin
            push_data.kind = CMD_FACT1;
            keep           = fact_in_range;
         end
         OP_LOAD_F2: begin
            push_data.kind = CMD_FACT2;
            keep           = fact_in_range;
         end
         OP_LOAD_F3: begin
            push_data.kind = CMD_FACT3;
            keep           = fact_in_range;
         end
         OP_QUERY: begin
            push_data.kind = CMD_QUERY;
            keep           = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push_valid = req_valid && keep;

endmodule

/* rtl/tte_queue.sv */
// short command queue between front end and back end
// depends on tte_pkg

module tte_queue import tte_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_data,
   output logic    full,
   output logic    pop_valid,
   input  logic    pop_en,
   output cmd_type pop_data
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full      = count_ff == CW'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_en && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/tte_back.sv */
// back end: owns the four stores, runs loads and the multiply-accumulate loop
// depends on tte_pkg and tte_ram

module tte_back import tte_pkg::*; #(
   parameter int RMAX = 8,
   parameter int NMAX = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [RANK_W-1:0] rank1,
   input  logic [RANK_W-1:0] rank2,
   input  logic [RANK_W-1:0] rank3,
   input  logic              q_valid,
   input  cmd_type           q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data
);

   localparam int CORE_WORDS = RMAX * RMAX * RMAX;
   localparam int FACT_WORDS = NMAX * RMAX;
   localparam int CAW        = (CORE_WORDS > 1) ? $clog2(CORE_WORDS) : 1;
   localparam int FAW        = (FACT_WORDS > 1) ? $clog2(FACT_WORDS) : 1;
   localparam int JW         = (RMAX > 1) ? $clog2(RMAX) : 1;
   localparam int RW         = RANK_W + 1;
   localparam int ACC_W      = WORD_W + 3 * JW + 1;

   back_state_type state_ff, state_in;

   logic [RANK_W-1:0] r1, r2, r3;
   logic [JW-1:0]     j1_ff, j1_in, j2_ff, j2_in, j3_ff, j3_in;
   logic [IDX_W-1:0]  idx1_ff, idx1_in, idx2_ff, idx2_in, idx3_ff, idx3_in;
   logic [2:0]        row_ok_ff, row_ok_in;
   logic              j1_end, j2_end, j3_end;
   logic              issue, issue_last;

   logic we_core, we_f1, we_f2, we_f3;
   logic [CAW-1:0] core_rd_addr;
   logic [FAW-1:0] f1_rd_addr, f2_rd_addr, f3_rd_addr;
   logic [WORD_W-1:0] core_q, f1_q, f2_q, f3_q;

   // multiply pipeline
   logic                     rd_valid_ff, rd_last_ff;
   logic                     a_valid_ff, a_last_ff, a_clip_ff;
   logic                     b_valid_ff, b_last_ff, b_clip_ff;
   logic                     c_valid_ff, c_last_ff, c_clip_ff;
   logic signed [WORD_W-1:0] fa, fb, fc;
   logic signed [WORD_W-1:0] ta_ff, a_fb_ff, a_fc_ff;
   logic signed [WORD_W-1:0] tb_ff, b_fc_ff;
   logic signed [WORD_W-1:0] tc_ff;
   qmul_type                 mul1, mul2, mul3;

   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     clip_ff, clip_in;
   logic                     acc_fits;
   rsp_type                  final_rsp;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // ranks above the store size are clamped
   assign r1 = (int'(rank1) > RMAX) ? RANK_W'(RMAX) : rank1;
   assign r2 = (int'(rank2) > RMAX) ? RANK_W'(RMAX) : rank2;
   assign r3 = (int'(rank3) > RMAX) ? RANK_W'(RMAX) : rank3;

   assign j1_end = (RW'(j1_ff) + RW'(1)) == RW'(r1);
   assign j2_end = (RW'(j2_ff) + RW'(1)) == RW'(r2);
   assign j3_end = (RW'(j3_ff) + RW'(1)) == RW'(r3);

   assign core_rd_addr = CAW'((int'(j1_ff) * RMAX + int'(j2_ff)) * RMAX + int'(j3_ff));
   assign f1_rd_addr   = FAW'(int'(idx1_ff) * RMAX + int'(j1_ff));
   assign f2_rd_addr   = FAW'(int'(idx2_ff) * RMAX + int'(j2_ff));
   assign f3_rd_addr   = FAW'(int'(idx3_ff) * RMAX + int'(j3_ff));

   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      issue        = 1'b0;
      issue_last   = 1'b0;
      we_core      = 1'b0;
      we_f1        = 1'b0;
      we_f2        = 1'b0;
      we_f3        = 1'b0;
      j1_in        = j1_ff;
      j2_in        = j2_ff;
      j3_in        = j3_ff;
      idx1_in      = idx1_ff;
      idx2_in      = idx2_ff;
      idx3_in      = idx3_ff;
      row_ok_in    = row_ok_ff;
      acc_in       = acc_ff;
      clip_in      = clip_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (c_valid_ff) begin
         acc_in  = acc_ff + ACC_W'(tc_ff);
         clip_in = clip_ff || c_clip_ff;
      end
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_data.kind)
                  CMD_CORE:  we_core = 1'b1;
                  CMD_FACT1: we_f1   = 1'b1;
                  CMD_FACT2: we_f2   = 1'b1;
                  CMD_FACT3: we_f3   = 1'b1;
                  CMD_QUERY: begin
                     idx1_in   = q_data.idx1;
                     idx2_in   = q_data.idx2;
                     idx3_in   = q_data.idx3;
                     row_ok_in = q_data.row_ok;
                     j1_in     = '0;
                     j2_in     = '0;
                     j3_in     = '0;
                     acc_in    = '0;
                     clip_in   = 1'b0;
                     // an empty sum goes straight to the result
                     if (r1 == '0 || r2 == '0 || r3 == '0) begin
                        state_in = BK_DONE;
                     end else begin
                        state_in = BK_RUN;
                     end
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         BK_RUN: begin
            issue      = 1'b1;
            issue_last = j1_end && j2_end && j3_end;
            if (j3_end) begin
               j3_in = '0;
               if (j2_end) begin
                  j2_in = '0;
                  j1_in = j1_ff + JW'(1);
               end else begin
                  j2_in = j2_ff + JW'(1);
               end
            end else begin
               j3_in = j3_ff + JW'(1);
            end
            if (issue_last) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (c_valid_ff && c_last_ff) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = final_rsp;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // final sum clipped to 32 bits
   assign acc_fits = (&acc_ff[ACC_W-1:WORD_W-1]) || !(|acc_ff[ACC_W-1:WORD_W-1]);
   always_comb begin
      final_rsp.saturated = clip_ff || !acc_fits;
      if (acc_fits) begin
         final_rsp.element_value = acc_ff[WORD_W-1:0];
      end else begin
         final_rsp.element_value = acc_ff[ACC_W-1] ? Q_MIN : Q_MAX;
      end
   end

   assign fa   = row_ok_ff[0] ? signed'(f1_q) : '0;
   assign fb   = row_ok_ff[1] ? signed'(f2_q) : '0;
   assign fc   = row_ok_ff[2] ? signed'(f3_q) : '0;
   assign mul1 = qmul(signed'(core_q), fa);
   assign mul2 = qmul(ta_ff, a_fb_ff);
   assign mul3 = qmul(tb_ff, b_fc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= issue;
         a_valid_ff   <= rd_valid_ff;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      j1_ff       <= j1_in;
      j2_ff       <= j2_in;
      j3_ff       <= j3_in;
      idx1_ff     <= idx1_in;
      idx2_ff     <= idx2_in;
      idx3_ff     <= idx3_in;
      row_ok_ff   <= row_ok_in;
      acc_ff      <= acc_in;
      clip_ff     <= clip_in;
      rsp_data_ff <= rsp_data_in;
      rd_last_ff  <= issue_last;
      ta_ff       <= mul1.value;
      a_clip_ff   <= mul1.clip;
      a_fb_ff     <= fb;
      a_fc_ff     <= fc;
      a_last_ff   <= rd_last_ff;
      tb_ff       <= mul2.value;
      b_clip_ff   <= a_clip_ff || mul2.clip;
      b_fc_ff     <= a_fc_ff;
      b_last_ff   <= a_last_ff;
      tc_ff       <= mul3.value;
      c_clip_ff   <= b_clip_ff || mul3.clip;
      c_last_ff   <= b_last_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   tte_ram #(.WIDTH(WORD_W), .DEPTH(CORE_WORDS), .AW(CAW)) u_core_ram (
      .clock   (clock),
      .wr_en   (we_core),
      .wr_addr (CAW'(q_data.addr)),
      .wr_data (q_data.value),
      .rd_en   (issue),
      .rd_addr (core_rd_addr),
      .rd_data (core_q)
   );

   tte_ram #(.WIDTH(WORD_W), .DEPTH(FACT_WORDS), .AW(FAW)) u_f1_ram (
      .clock   (clock),
      .wr_en   (we_f1),
      .wr_addr (FAW'(q_data.addr)),
      .wr_data (q_data.value),
      .rd_en   (issue),
      .rd_addr (f1_rd_addr),
      .rd_data (f1_q)
   );

   tte_ram #(.WIDTH(WORD_W), .DEPTH(FACT_WORDS), .AW(FAW)) u_f2_ram (
      .clock   (clock),
      .wr_en   (we_f2),
      .wr_addr (FAW'(q_data.addr)),
      .wr_data (q_data.value),
      .rd_en   (issue),
      .rd_addr (f2_rd_addr),
      .rd_data (f2_q)
   );

   tte_ram #(.WIDTH(WORD_W), .DEPTH(FACT_WORDS), .AW(FAW)) u_f3_ram (
      .clock   (clock),
      .wr_en   (we_f3),
      .wr_addr (FAW'(q_data.addr)),
      .wr_data (q_data.value),
      .rd_en   (issue),
      .rd_addr (f3_rd_addr),
      .rd_data (f3_q)
   );

endmodule

/* rtl/tucker_tensor_element_eval.sv */
// Tucker-form tensor element evaluator. Loads write one word of the core or of a
// factor matrix and give no result; a query returns the signed Q16.16 element
// (i1,i2,i3) as the sum of core*f1*f2*f3 over the configured ranks. Items enter a
// two-entry queue after decoding; the back end takes one load per cycle while idle
// and runs a query as one multiply-accumulate term per cycle through a
// three-multiplier chain. Each of the four stores has a single read port. Ranks
// above RMAX act as RMAX; a zero rank gives 0. Every core or factor word a query
// uses must have been loaded first.
// depends on tte_pkg, tte_front, tte_queue, tte_back

module tucker_tensor_element_eval import tte_pkg::*; #(
   parameter int RMAX = 8,
   parameter int NMAX = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RANK_W-1:0]    csr_wdata
);

   logic [RANK_W-1:0] rank1_ff, rank1_in;
   logic [RANK_W-1:0] rank2_ff, rank2_in;
   logic [RANK_W-1:0] rank3_ff, rank3_in;

   logic    push_valid;
   cmd_type push_data;
   logic    q_full;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_data;

   always_comb begin
      rank1_in = rank1_ff;
      rank2_in = rank2_ff;
      rank3_in = rank3_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RANK_FIRST:  rank1_in = csr_wdata;
            CSR_RANK_SECOND: rank2_in = csr_wdata;
            CSR_RANK_THIRD:  rank3_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank1_ff <= RANK_W'(1);
         rank2_ff <= RANK_W'(1);
         rank3_ff <= RANK_W'(1);
      end else begin
         rank1_ff <= rank1_in;
         rank2_ff <= rank2_in;
         rank3_ff <= rank3_in;
      end
   end

   assign req_stall = q_full;

   tte_front #(.RMAX(RMAX), .NMAX(NMAX)) u_front (
      .req_valid  (req_valid),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   tte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_en     (q_pop),
      .pop_data   (q_data)
   );

   tte_back #(.RMAX(RMAX), .NMAX(NMAX)) u_back (
      .clock     (clock),
      .reset     (reset),
      .rank1     (rank1_ff),
      .rank2     (rank2_ff),
      .rank3     (rank3_ff),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/tte_checker.sv */
// port-level checks for the tucker element evaluator, bound to the top level
// depends on tte_pkg and tucker_tensor_element_eval

module tte_checker import tte_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // queries accepted whose results are not yet taken
   logic [3:0] pending_ff, pending_in;
   logic       query_in;
   logic       result_out;

   assign query_in   = req_valid && !req_stall && req_data.operation == OP_QUERY;
   assign result_out = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (query_in && !result_out) begin
         pending_in = pending_ff + 4'd1;
      end else if (result_out && !query_in) begin
         pending_in = pending_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_no_orphan_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("result without an outstanding query");

endmodule

bind tucker_tensor_element_eval tte_checker u_checker (.*);

/* tb/tb_tucker_tensor_element_eval.sv */
// self-checking testbench for tucker_tensor_element_eval: directed and random
// core/factor loads and element queries, checked against an in-bench Q16.16 model
// depends on tte_pkg and tucker_tensor_element_eval
`timescale 1ns / 100ps

module tb_tucker_tensor_element_eval;
   import tte_pkg::*;

   localparam int RMAX         = 8;
   localparam int NMAX         = 64;
   localparam int CORE_WORDS   = RMAX * RMAX * RMAX;
   localparam int FACTOR_WORDS = NMAX * RMAX;
   localparam int PHASE_ITEMS  = 80;
   localparam int DRAIN_CYCLES = 32;
   localparam int TAIL_CYCLES  = 600;
   localparam int CYCLE_LIMIT  = 4_000_000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [RANK_W-1:0]    csr_wdata = '0;

   // shadow of the block's stores and rank registers
   logic signed [WORD_W-1:0] core_words [CORE_WORDS];
   logic signed [WORD_W-1:0] factor_words [3][FACTOR_WORDS];
   bit                       core_written [CORE_WORDS];
   bit                       factor_written [3][FACTOR_WORDS];
   logic [RANK_W-1:0]        rank_regs [3];

   rsp_type pending_elements [$];
   int      item_count;
   int      error_count;
   int      cycle_count;
   int      stall_run;
   bit      idling;
   bit      value_wild;

   tucker_tensor_element_eval #(.RMAX(RMAX), .NMAX(NMAX)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side back-pressure in short bursts
   always @(posedge clock) begin
      if (reset || !idling) begin
         stall_run = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (stall_run == 0 && $urandom_range(0, 4) == 0) begin
            stall_run = $urandom_range(1, 3);
         end
         rsp_stall <= (stall_run != 0);
         if (stall_run != 0) begin
            stall_run--;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_elements.size() == 0) begin
            $error("element result with no query pending: value %0d saturated %0b",
                   $signed(rsp_data.element_value), rsp_data.saturated);
            error_count++;
         end else begin
            want = pending_elements.pop_front();
            if (rsp_data.element_value !== want.element_value) begin
               $error("element_value: expected %0d, got %0d",
                      $signed(want.element_value), $signed(rsp_data.element_value));
               error_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated: expected %0b, got %0b", want.saturated, rsp_data.saturated);
               error_count++;
            end
         end
      end
   end

   function automatic int eff_rank(input logic [RANK_W-1:0] r);
      return (r > RMAX) ? RMAX : int'(r);
   endfunction

   function automatic rsp_type clamp_word(input longint x);
      rsp_type r;
      if (x > longint'(Q_MAX)) begin
         r.element_value = Q_MAX;
         r.saturated = 1'b1;
      end else if (x < longint'(Q_MIN)) begin
         r.element_value = Q_MIN;
         r.saturated = 1'b1;
      end else begin
         r.element_value = x[WORD_W-1:0];
         r.saturated = 1'b0;
      end
      return r;
   endfunction

   // arithmetic shift is a floor division by 2^16
   function automatic rsp_type q16_mul(input logic signed [WORD_W-1:0] a,
                                       input logic signed [WORD_W-1:0] b);
      return clamp_word((longint'(a) * longint'(b)) >>> FRAC_W);
   endfunction

   function automatic rsp_type reconstruct_element(input int i1, input int i2, input int i3);
      int      n1, n2, n3;
      longint  acc;
      logic    clip;
      rsp_type term;
      rsp_type total;
      n1 = eff_rank(rank_regs[0]);
      n2 = eff_rank(rank_regs[1]);
      n3 = eff_rank(rank_regs[2]);
      acc = 0;
      clip = 1'b0;
      for (int j1 = 0; j1 < n1; j1++) begin
         for (int j2 = 0; j2 < n2; j2++) begin
            for (int j3 = 0; j3 < n3; j3++) begin
               term = q16_mul(core_words[(j1 * RMAX + j2) * RMAX + j3],
                              factor_words[0][i1 * RMAX + j1]);
               clip |= term.saturated;
               term = q16_mul(term.element_value, factor_words[1][i2 * RMAX + j2]);
               clip |= term.saturated;
               term = q16_mul(term.element_value, factor_words[2][i3 * RMAX + j3]);
               clip |= term.saturated;
               acc += $signed(term.element_value);
            end
         end
      end
      total = clamp_word(acc);
      total.saturated = total.saturated | clip;
      return total;
   endfunction

   function automatic req_type random_fields();
      req_type item;
      item.operation    = OP_QUERY;
      item.load_address = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
      item.load_value   = $urandom();
      item.index_first  = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      item.index_second = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      item.index_third  = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      return item;
   endfunction

   // tame words keep full-rank sums inside the q16.16 range
   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(0, value_wild ? 11 : 7))
         0: return '0;
         1: return 32'sh0001_0000;
         2: return -32'sh0001_0000;
         3: return -32'sh1;
         8: return Q_MAX;
         9: return Q_MIN;
         10, 11: return $urandom();
         default: return $urandom_range(0, 32'h0004_0000) - 32'sh0002_0000;
      endcase
   endfunction

   function automatic int pick_index();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, NMAX - 1) : $urandom_range(0, 7);
   endfunction

   task automatic issue_item(input req_type item);
      int mode;
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (item.operation)
         OP_LOAD_CORE: begin
            core_words[item.load_address] = item.load_value;
            core_written[item.load_address] = 1'b1;
            item_count++;
         end
         OP_LOAD_F1, OP_LOAD_F2, OP_LOAD_F3: begin
            mode = item.operation - OP_LOAD_F1;
            factor_words[mode][item.load_address] = item.load_value;
            factor_written[mode][item.load_address] = 1'b1;
            item_count++;
         end
         OP_QUERY: begin
            pending_elements.push_back(reconstruct_element(item.index_first,
                                                           item.index_second,
                                                           item.index_third));
            item_count++;
         end
         default: ; // unused codes are dropped by the block
      endcase
   endtask

   task automatic put_word(input op_type op, input int addr,
                           input logic signed [WORD_W-1:0] value);
      req_type item;
      item = random_fields();
      item.operation = op;
      item.load_address = ADDR_W'(addr);
      item.load_value = value;
      issue_item(item);
   endtask

   task automatic load_word(input op_type op, input int addr);
      put_word(op, addr, pick_word());
   endtask

   // loads every word the query will read that has not been written yet, then issues the query
   task automatic query_element(input int i1, input int i2, input int i3);
      int      rows [3];
      int      n [3];
      req_type item;
      rows = '{i1, i2, i3};
      for (int m = 0; m < 3; m++) n[m] = eff_rank(rank_regs[m]);
      if (n[0] * n[1] * n[2] != 0) begin
         for (int m = 0; m < 3; m++) begin
            for (int j = 0; j < n[m]; j++) begin
               if (!factor_written[m][rows[m] * RMAX + j]) begin
                  load_word(op_type'(OP_LOAD_F1 + m), rows[m] * RMAX + j);
               end
            end
         end
         for (int j1 = 0; j1 < n[0]; j1++) begin
            for (int j2 = 0; j2 < n[1]; j2++) begin
               for (int j3 = 0; j3 < n[2]; j3++) begin
                  if (!core_written[(j1 * RMAX + j2) * RMAX + j3]) begin
                     load_word(OP_LOAD_CORE, (j1 * RMAX + j2) * RMAX + j3);
                  end
               end
            end
         end
      end
      item = random_fields();
      item.operation = OP_QUERY;
      item.index_first = IDX_W'(i1);
      item.index_second = IDX_W'(i2);
      item.index_third = IDX_W'(i3);
      issue_item(item);
   endtask

   task automatic wait_drained(input int extra);
      req_valid <= 1'b0;
      while (pending_elements.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic program_ranks(input int r1, input int r2, input int r3);
      int r [3];
      r = '{r1, r2, r3};
      wait_drained(DRAIN_CYCLES);
      for (int m = 0; m < 3; m++) begin
         csr_wr_en <= 1'b1;
         csr_index <= csr_reg_type'(CSR_RANK_FIRST + m);
         csr_wdata <= RANK_W'(r[m]);
         @(posedge clock);
         rank_regs[m] = RANK_W'(r[m]);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_single_terms();
      // reset ranks are 1, so each query is one four-way product
      put_word(OP_LOAD_CORE, 0, 32'sh0001_8000);
      put_word(OP_LOAD_F1, 0, -32'sh0000_8001);
      put_word(OP_LOAD_F2, 0, 32'sh0002_0000);
      put_word(OP_LOAD_F3, 0, 32'sh0000_0003);
      query_element(0, 0, 0);
      put_word(OP_LOAD_F1, (NMAX - 1) * RMAX, Q_MIN);
      put_word(OP_LOAD_F2, (NMAX - 1) * RMAX, Q_MAX);
      put_word(OP_LOAD_F3, (NMAX - 1) * RMAX, Q_MAX);
      query_element(NMAX - 1, NMAX - 1, NMAX - 1);
      put_word(OP_LOAD_CORE, CORE_WORDS - 1, Q_MAX);
      put_word(OP_LOAD_F3, FACTOR_WORDS - 1, Q_MIN);
      query_element(0, NMAX - 1, 0);
      query_element(NMAX - 1, 0, NMAX - 1);
   endtask

   task automatic test_ignored_codes();
      req_type item;
      // codes above the query must leave the stores alone
      for (int k = 1; k <= 3; k++) begin
         item = random_fields();
         item.operation = OP_W'(int'(OP_QUERY) + k);
         item.load_address = '0;
         issue_item(item);
      end
      query_element(0, 0, 0);
   endtask

   task automatic test_zero_rank();
      program_ranks(0, 1, 1);
      query_element(NMAX - 1, NMAX - 1, NMAX - 1);
      program_ranks(1, 1, 0);
      query_element(0, 0, 0);
      program_ranks(0, 0, 0);
      query_element(0, NMAX - 1, 0);
   endtask

   task automatic test_random_phase(input int r1, input int r2, input int r3,
                                    input bit wild, input bit idle);
      int      first;
      int      pick;
      req_type item;
      program_ranks(r1, r2, r3);
      value_wild = wild;
      idling = idle;
      first = item_count;
      while (item_count - first < PHASE_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick < 10) begin
            query_element(pick_index(), pick_index(), pick_index());
         end else if (pick < 18) begin
            load_word(op_type'($urandom_range(OP_LOAD_CORE, OP_LOAD_F3)),
                      $urandom_range(0, (1 << ADDR_W) - 1));
         end else begin
            item = random_fields();
            item.operation = OP_W'(int'(OP_QUERY) + int'($urandom_range(1, 3)));
            issue_item(item);
         end
      end
   endtask

   initial begin
      rank_regs = '{1, 1, 1};
      idling = 1'b1;
      value_wild = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_single_terms();
      test_ignored_codes();
      test_zero_rank();
      test_random_phase(8, 8, 8, 1'b0, 1'b1);
      test_random_phase(15, 15, 15, 1'b0, 1'b1);
      test_random_phase(1, 1, 1, 1'b1, 1'b1);
      test_random_phase(0, 5, 3, 1'b1, 1'b0);
      test_random_phase(2, 8, 4, 1'b0, 1'b1);
      test_random_phase($urandom_range(0, 15), $urandom_range(0, 15),
                        $urandom_range(0, 15), 1'b1, 1'b1);
      test_random_phase($urandom_range(0, 15), $urandom_range(0, 15),
                        $urandom_range(0, 15), 1'b0, 1'b1);
      test_random_phase(15, 9, 3, 1'b1, 1'b1);
      test_random_phase(8, 8, 8, 1'b0, 1'b0);
      wait_drained(TAIL_CYCLES);
      if (error_count == 0 && pending_elements.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
